/* rtl/spl_pkg.sv */
// Package for the sorted priority list: sizes, request and status codes,
// entry and cell control types. No dependencies.
package spl_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned SCORE_W  = 8;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned OUT_CNT_W = 6;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 104;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [TIME_W-1:0]  when_time;
    logic               visible;
    logic               clearable;
  } entry_t;

  // Request broadcast to every cell
  typedef struct packed {
    logic   cmp_en;  // latch compare results against the request
    logic   ins_en;  // commit an insert
    logic   rem_en;  // commit a remove
    entry_t req;     // request entry (key, sort keys, flags)
  } cell_ctrl_t;

endpackage

/* rtl/spl_cell.sv */
// One slot of the sorted list chain: holds an entry, compares it with the
// request and shifts toward either neighbor. Depends on spl_pkg.
module spl_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spl_pkg::cell_ctrl_t ctrl_i,
  input  logic               occ_i,        // slot holds a live entry
  input  spl_pkg::entry_t    left_ent_i,   // entry of the lower neighbor
  input  spl_pkg::entry_t    right_ent_i,  // entry of the upper neighbor
  input  logic               left_ins_i,   // lower neighbor is at/after insert point
  input  logic               seen_i,       // a key match exists below this slot
  output spl_pkg::entry_t    ent_o,
  output spl_pkg::entry_t    ent_d_o,
  output logic               ins_o,
  output logic               seen_o,
  output logic               hit_o
);

  spl_pkg::entry_t ent_q, ent_d;
  logic            gt_q, match_q;
  logic            gt_now, mm;

  // Strictly greater: signed score first, then full timestamp
  always_comb begin
    if (ent_q.score != ctrl_i.req.score) begin
      gt_now = $signed(ent_q.score) > $signed(ctrl_i.req.score);
    end else begin
      gt_now = ent_q.when_time > ctrl_i.req.when_time;
    end
  end

  // Compare flags, latched in the compare state ahead of the update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q    <= 1'b0;
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      gt_q    <= gt_now;
      match_q <= (ent_q.key == ctrl_i.req.key);
    end
  end

  assign ins_o  = gt_q | ~occ_i;
  assign mm     = match_q & occ_i;
  assign seen_o = seen_i | mm;
  assign hit_o  = mm & ~seen_i;

  // Shift right on insert, left on remove
  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.ins_en) begin
      if (left_ins_i) begin
        ent_d = left_ent_i;
      end else if (ins_o) begin
        ent_d = ctrl_i.req;
      end
    end else if (ctrl_i.rem_en) begin
      if (seen_i | mm) begin
        ent_d = right_ent_i;
      end
    end
  end

  // Entry payload, no reset
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o   = ent_q;
  assign ent_d_o = ent_d;

endmodule

/* rtl/sorted_priority_list_top.sv */
// Top level of the sorted priority list: request/result streams, control
// sequencer and the chain of spl_cell slots. Depends on spl_pkg, spl_cell.
//
//  Channel   Dir  Group        Contents
//  request   in   s_axis_*     tuser: req_type; tdata: key, score, when_time,
//                               visible, clearable, position
//  result    out  m_axis_*     tuser: status; tdata: index, entry fields,
//                               count, any_visible, any_clearable
//
// Each request passes through a compare state, where every cell compares its
// entry with the request, then an update state, where the chain shifts and the
// result is registered. The next request is taken in the update state. Reset
// empties the list at once (count cleared, no clearing pass). A stalled result
// holds the update state, and with it the request side, until the result is taken.
module sorted_priority_list_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] key, [39:32] score, [87:40] when_time, [88] visible,
  // [89] clearable, [94:90] position, [95] zero
  input  logic [spl_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] index, [36:5] entry_key, [44:37] entry_score, [92:45] entry_time,
  // [93] entry_visible, [94] entry_clearable, [100:95] count,
  // [101] any_visible, [102] any_clearable, [103] zero
  output logic [spl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  localparam int unsigned N = spl_pkg::CAPACITY;

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_UPD} state_e;

  state_e                         state_q, state_d;
  logic                           m_valid_q;
  logic [spl_pkg::OUT_TDATA_W-1:0] m_data_q;
  logic [1:0]                     m_user_q;
  logic [spl_pkg::CNT_W-1:0]      count_q, count_d;

  spl_pkg::req_type_e             req_type_q;
  spl_pkg::entry_t                req_q;
  logic [spl_pkg::POS_W-1:0]      pos_q;

  spl_pkg::cell_ctrl_t            ctrl;
  spl_pkg::entry_t                ent   [N];
  spl_pkg::entry_t                ent_d [N];
  logic [N-1:0]                   occ, occ_d, ins_v, hit;
  logic [N:0]                     seen;

  logic done, accept, full, found;
  logic [N-1:0]                   sel;
  spl_pkg::entry_t                sel_ent;
  spl_pkg::status_e               status;
  logic [spl_pkg::IDX_W-1:0]      index;
  logic                           any_vis, any_clr;

  // Handshake and sequencing
  assign done          = (state_q == ST_UPD) && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE) || done;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == spl_pkg::CNT_W'(N));
  assign found         = |hit;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD: begin
        if (done) state_d = accept ? ST_CMP : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Cell control broadcast
  always_comb begin
    ctrl.cmp_en = (state_q == ST_CMP);
    ctrl.ins_en = done && (req_type_q == spl_pkg::REQ_INSERT) && !full;
    ctrl.rem_en = done && (req_type_q == spl_pkg::REQ_REMOVE) && found;
    ctrl.req    = req_q;
  end

  // Occupancy from the count, before and after the update
  always_comb begin
    count_d = count_q;
    if (ctrl.ins_en) count_d = count_q + spl_pkg::CNT_W'(1);
    else if (ctrl.rem_en) count_d = count_q - spl_pkg::CNT_W'(1);
  end

  for (genvar i = 0; i < N; i++) begin : g_occ
    assign occ[i]   = spl_pkg::CNT_W'(i) < count_q;
    assign occ_d[i] = spl_pkg::CNT_W'(i) < count_d;
  end

  // Cell chain
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < N; i++) begin : g_cell
    spl_pkg::entry_t left_ent, right_ent;
    logic            left_ins;
    if (i == 0) begin : g_first
      assign left_ent = ent[i];
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_ent = ent[i-1];
      assign left_ins = ins_v[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_up
      assign right_ent = ent[i+1];
    end
    spl_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .left_ent_i  (left_ent),
      .right_ent_i (right_ent),
      .left_ins_i  (left_ins),
      .seen_i      (seen[i]),
      .ent_o       (ent[i]),
      .ent_d_o     (ent_d[i]),
      .ins_o       (ins_v[i]),
      .seen_o      (seen[i+1]),
      .hit_o       (hit[i])
    );
  end

  // Result: slot select, index encode, entry mux, summary flags
  always_comb begin
    sel     = '0;
    status  = spl_pkg::STAT_MISS;
    index   = '0;
    sel_ent = '0;
    any_vis = 1'b0;
    any_clr = 1'b0;
    unique case (req_type_q)
      spl_pkg::REQ_INSERT: begin
        if (full) begin
          status = spl_pkg::STAT_FULL;
        end else begin
          status = spl_pkg::STAT_OK;
          for (int i = 0; i < N; i++) begin
            if (ins_v[i] && (i == 0 || !ins_v[(i == 0) ? 0 : i - 1])) begin
              index = index | spl_pkg::IDX_W'(i);
            end
          end
        end
      end
      spl_pkg::REQ_REMOVE: begin
        sel = hit;
        if (found) status = spl_pkg::STAT_OK;
      end
      spl_pkg::REQ_READ: begin
        for (int i = 0; i < N; i++) begin
          sel[i] = occ[i] && (int'(pos_q) == i);
        end
        if (|sel) status = spl_pkg::STAT_OK;
      end
      default: status = spl_pkg::STAT_MISS;
    endcase
    if (req_type_q != spl_pkg::REQ_INSERT) begin
      for (int i = 0; i < N; i++) begin
        if (sel[i]) begin
          index   = index | spl_pkg::IDX_W'(i);
          sel_ent = sel_ent | ent[i];
        end
      end
    end
    for (int i = 0; i < N; i++) begin
      if (occ_d[i] && ent_d[i].visible) begin
        any_vis = 1'b1;
        if (ent_d[i].clearable) any_clr = 1'b1;
      end
    end
  end

  // Sequencer state, count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (done) begin
        m_valid_q <= 1'b1;
        m_user_q  <= status;
        m_data_q  <= {1'b0, any_clr, any_vis, spl_pkg::OUT_CNT_W'(count_d),
                      sel_ent.clearable, sel_ent.visible, sel_ent.when_time,
                      sel_ent.score, sel_ent.key, index};
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Request register, payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q      <= spl_pkg::req_type_e'(s_axis_tuser);
      req_q.key       <= s_axis_tdata[31:0];
      req_q.score     <= s_axis_tdata[39:32];
      req_q.when_time <= s_axis_tdata[87:40];
      req_q.visible   <= s_axis_tdata[88];
      req_q.clearable <= s_axis_tdata[89];
      pos_q           <= s_axis_tdata[94:90];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
